[design/disco_pixel_sparkle_generator_assert.svh]
// Assertion macros shared by the sparkle generator modules
`ifndef DISCO_PIXEL_SPARKLE_GENERATOR_ASSERT_SVH
`define DISCO_PIXEL_SPARKLE_GENERATOR_ASSERT_SVH

// Checked at every rising edge of clk, held off while rst_n is low
`define DPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included
`define DPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/dps_pkg.sv]
// Shared constants, types and functions of the sparkle generator
package dps_pkg;

    localparam int PIXEL_COUNT  = 32;
    localparam int FADE_HALF_MS = 512;

    localparam int PIX_W  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int FADE_W = $clog2(FADE_HALF_MS + 1);

    localparam int NUM_W  = 28;
    localparam int DEN_W  = 20;
    localparam int QUOT_W = 8;
    localparam int STEP_W = $clog2(QUOT_W);

    localparam int LIFE_W = 10;
    localparam logic [LIFE_W-1:0] LIFE_RESET = 10'd400;
    localparam logic [LIFE_W-1:0] LIFE_BASE  = 10'd400;
    localparam logic [LIFE_W:0]   RESPAWN_GRACE = 11'd100;

    localparam logic [7:0]  MB_RESET   = 8'hFF;
    localparam logic [15:0] SEED_RESET = 16'd1337;

    localparam logic REG_MASTER_BRIGHTNESS = 1'b0;
    localparam logic REG_RANDOM_SEED       = 1'b1;

    localparam logic KIND_RESTART = 1'b0;

    typedef struct packed {
        logic busy;
        logic done;
    } dps_div_stat_t;

    function automatic logic [15:0] lcg_step(input logic [15:0] g);
        logic [31:0] p;
        begin
            p = 32'(g) * 32'd2053 + 32'd13849;
            return p[15:0];
        end
    endfunction

    function automatic logic [2:0] colour_draw(input logic [15:0] g);
        logic [7:0]  b;
        logic [10:0] p;
        begin
            b = g[7:0] + g[15:8];
            p = 11'(b) * 11'd6;
            return p[10:8];
        end
    endfunction

    function automatic logic [LIFE_W-1:0] life_draw(input logic [15:0] g);
        logic [24:0] p;
        begin
            p = 25'(g) * 25'd500;
            return LIFE_BASE + LIFE_W'(p[24:16]);
        end
    endfunction

    function automatic logic [23:0] colour_rgb(input logic [2:0] c);
        logic [23:0] v;
        begin
            unique case (c)
                3'd0:    v = 24'hFF0000;
                3'd1:    v = 24'h0000FF;
                3'd2:    v = 24'hFFFF00;
                3'd3:    v = 24'h008000;
                3'd4:    v = 24'h00FFFF;
                3'd5:    v = 24'hEE82EE;
                default: v = 24'h000000;
            endcase
            return v;
        end
    endfunction

    function automatic logic [7:0] dim(input logic [7:0] c, input logic [7:0] s);
        logic [16:0] p;
        begin
            p = 17'(c) * (17'(s) + 17'd1);
            return p[15:8];
        end
    endfunction

endpackage

[design/dps_if.sv]
// Item and result channel interfaces
interface dps_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] now_ms;

    modport source (output valid, kind, now_ms, input ready);
    modport sink   (input valid, kind, now_ms, output ready);
endinterface

interface dps_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] global_brightness;
    logic       has_pixel;
    logic       last;

    modport source (output valid, pixel_index, red, green, blue, global_brightness,
                    has_pixel, last, input ready);
    modport sink   (input valid, pixel_index, red, green, blue, global_brightness,
                    has_pixel, last, output ready);
endinterface

[design/dps_divider.sv]
// Shared restoring divider, one quotient bit per cycle
`include "disco_pixel_sparkle_generator_assert.svh"

module dps_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dps_pkg::NUM_W-1:0]   num,
    input  logic [dps_pkg::DEN_W-1:0]   den,
    output dps_pkg::dps_div_stat_t      stat,
    output logic [dps_pkg::QUOT_W-1:0]  quot
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [dps_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [dps_pkg::NUM_W-1:0]    rem_reg, rem_next;
    logic [dps_pkg::DEN_W-1:0]    den_reg, den_next;
    logic [dps_pkg::QUOT_W-1:0]   q_reg, q_next;
    logic [dps_pkg::NUM_W:0]      shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        shifted   = (dps_pkg::NUM_W+1)'(den_reg) << step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = dps_pkg::STEP_W'(dps_pkg::QUOT_W - 1);
            rem_next  = num;
            den_next  = den;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= shifted)
            begin
                rem_next       = rem_reg - dps_pkg::NUM_W'(shifted);
                q_next[step_reg] = 1'b1;
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

    `DPS_ASSERT(a_start_then_busy, start |=> busy_reg, "divider did not start")
    `DPS_ASSERT(a_done_not_busy, done_reg |-> !busy_reg, "divider done while busy")
    `DPS_ASSERT(a_done_after_last_step, done_reg |-> $past(busy_reg) && $past(step_reg) == '0,
        "divider done without final step")
    `DPS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !done_reg, "divider done out of reset")

endmodule

[design/disco_pixel_sparkle_generator.sv]
// Top level: sparkle sequencer, pixel state, config port and result register
//
//  channel  | dir | transfer
//  ---------+-----+-----------------------------------------------
//  item     | in  | kind, now_ms on valid & ready
//  result   | out | pixel_index, rgb, brightness, flags on valid & ready
//  apb      | in  | register write on psel & penable & pwrite
//
// Restart: accept the item, then per pixel the spawn steps SP1 and SP2.
// Frame in normal mode: accept the item, then per pixel inside its life load, two multiply
// steps, the 8-step shared divider and emit, or outside it load, the multiply steps and
// emit; a pixel past its life and the respawn grace then respawns (SP1, SP2).
// Fade frame: accept the item, then F1, the divider and emit, or F1 and emit once the fade has run out.
// item.ready is high only while idle; a full result register stalls the emit step.
// Reset is asynchronous, active low.
`include "disco_pixel_sparkle_generator_assert.svh"

module disco_pixel_sparkle_generator (
    input  logic        clk,
    input  logic        rst_n,
    dps_in_if.sink      item,
    dps_out_if.source   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_MUL2  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_EMIT  = 4'd5;
    localparam logic [3:0] S_SP1   = 4'd6;
    localparam logic [3:0] S_SP2   = 4'd7;
    localparam logic [3:0] S_F1    = 4'd8;
    localparam logic [3:0] S_FDIV  = 4'd9;
    localparam logic [3:0] S_FEMIT = 4'd10;

    localparam logic [dps_pkg::PIX_W-1:0] LAST_IDX = dps_pkg::PIX_W'(dps_pkg::PIXEL_COUNT - 1);
    localparam int LW = dps_pkg::LIFE_W;

    logic [3:0]                 state_reg, state_next;
    logic [dps_pkg::PIX_W-1:0]  idx_reg, idx_next;
    logic                       restart_reg, restart_next;
    logic [31:0]                now_reg, now_next;
    logic [31:0]                d_reg, d_next;
    logic                       in_life_reg, in_life_next;
    logic                       over_reg, over_next;
    logic [LW-1:0]              life_reg, life_next;
    logic [2:0]                 col_reg, col_next;
    logic [2*LW-1:0]            prod_reg, prod_next;
    logic [7:0]                 s_reg, s_next;
    logic                       fading_reg, fading_next;
    logic [31:0]                eff_reg, eff_next;
    logic [15:0]                gen_reg, gen_next;
    logic [7:0]                 mb_reg, mb_next;
    logic [15:0]                seed_reg, seed_next;

    logic                       ov_reg, ov_next;
    logic [5:0]                 oidx_reg, oidx_next;
    logic [7:0]                 ored_reg, ored_next;
    logic [7:0]                 ogrn_reg, ogrn_next;
    logic [7:0]                 oblu_reg, oblu_next;
    logic [7:0]                 obr_reg, obr_next;
    logic                       ohp_reg, ohp_next;
    logic                       olast_reg, olast_next;

    logic [31:0]                start_mem_reg [dps_pkg::PIXEL_COUNT];
    logic [2:0]                 col_mem_reg   [dps_pkg::PIXEL_COUNT];
    logic [LW-1:0]              life_mem_reg  [dps_pkg::PIXEL_COUNT];
    logic                       we_spawn, we_life;
    logic [15:0]                gen_step;

    logic                       div_start;
    logic [dps_pkg::NUM_W-1:0]  div_num;
    logic [dps_pkg::DEN_W-1:0]  div_den;
    dps_pkg::dps_div_stat_t     div_stat;
    logic [dps_pkg::QUOT_W-1:0] div_quot;

    logic                       ofree;
    logic                       cfg_wr;
    logic [23:0]                rgb;
    logic [dps_pkg::FADE_W-1:0] fade_left;

    dps_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    assign ofree     = !ov_reg || result.ready;
    assign cfg_wr    = psel && penable && pwrite;
    assign gen_step  = dps_pkg::lcg_step(gen_reg);
    assign rgb       = dps_pkg::colour_rgb(col_reg);
    assign fade_left = dps_pkg::FADE_W'(dps_pkg::FADE_HALF_MS) - d_reg[dps_pkg::FADE_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        restart_next = restart_reg;
        now_next     = now_reg;
        d_next       = d_reg;
        in_life_next = in_life_reg;
        over_next    = over_reg;
        life_next    = life_reg;
        col_next     = col_reg;
        prod_next    = prod_reg;
        s_next       = s_reg;
        fading_next  = fading_reg;
        eff_next     = eff_reg;
        gen_next     = gen_reg;
        mb_next      = mb_reg;
        seed_next    = seed_reg;
        ov_next      = ov_reg;
        oidx_next    = oidx_reg;
        ored_next    = ored_reg;
        ogrn_next    = ogrn_reg;
        oblu_next    = oblu_reg;
        obr_next     = obr_reg;
        ohp_next     = ohp_reg;
        olast_next   = olast_reg;
        we_spawn     = 1'b0;
        we_life      = 1'b0;
        div_start    = 1'b0;
        div_num      = '0;
        div_den      = '0;

        if (ov_reg && result.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    now_next = item.now_ms;
                    idx_next = '0;
                    if (item.kind == dps_pkg::KIND_RESTART)
                    begin
                        restart_next = 1'b1;
                        eff_next     = item.now_ms;
                        fading_next  = 1'b1;
                        state_next   = S_SP1;
                    end
                    else if (fading_reg)
                    begin
                        d_next     = item.now_ms - eff_reg;
                        state_next = S_F1;
                    end
                    else
                    begin
                        restart_next = 1'b0;
                        state_next   = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                d_next     = now_reg - start_mem_reg[idx_reg];
                life_next  = life_mem_reg[idx_reg];
                col_next   = col_mem_reg[idx_reg];
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                in_life_next = d_reg <= 32'(life_reg);
                over_next    = {1'b0, d_reg} > 33'({1'b0, life_reg} + dps_pkg::RESPAWN_GRACE);
                prod_next    = (2*LW)'(d_reg[LW-1:0]) * (2*LW)'(life_reg - d_reg[LW-1:0]);
                state_next   = S_MUL2;
            end
            S_MUL2:
            begin
                if (in_life_reg)
                begin
                    div_start  = 1'b1;
                    div_num    = dps_pkg::NUM_W'((dps_pkg::NUM_W+2)'(prod_reg) * 30'd1020);
                    div_den    = dps_pkg::DEN_W'((2*LW)'(life_reg) * (2*LW)'(life_reg));
                    state_next = S_DIV;
                end
                else
                begin
                    s_next     = '0;
                    state_next = S_EMIT;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    s_next     = div_quot;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (ofree)
                begin
                    ov_next    = 1'b1;
                    oidx_next  = 6'(idx_reg);
                    ored_next  = dps_pkg::dim(rgb[23:16], s_reg);
                    ogrn_next  = dps_pkg::dim(rgb[15:8], s_reg);
                    oblu_next  = dps_pkg::dim(rgb[7:0], s_reg);
                    obr_next   = mb_reg;
                    ohp_next   = 1'b1;
                    olast_next = idx_reg == LAST_IDX;
                    if (over_reg)
                    begin
                        state_next = S_SP1;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            S_SP1:
            begin
                gen_next   = gen_step;
                we_spawn   = 1'b1;
                state_next = S_SP2;
            end
            S_SP2:
            begin
                gen_next = gen_step;
                we_life  = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = restart_reg ? S_SP1 : S_LOAD;
                end
            end
            S_F1:
            begin
                if (d_reg > 32'(dps_pkg::FADE_HALF_MS))
                begin
                    fading_next = 1'b0;
                    s_next      = mb_reg;
                    state_next  = S_FEMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = dps_pkg::NUM_W'(mb_reg) * dps_pkg::NUM_W'(fade_left);
                    div_den    = dps_pkg::DEN_W'(dps_pkg::FADE_HALF_MS);
                    state_next = S_FDIV;
                end
            end
            S_FDIV:
            begin
                if (div_stat.done)
                begin
                    s_next     = div_quot;
                    state_next = S_FEMIT;
                end
            end
            S_FEMIT:
            begin
                if (ofree)
                begin
                    ov_next    = 1'b1;
                    oidx_next  = '0;
                    ored_next  = '0;
                    ogrn_next  = '0;
                    oblu_next  = '0;
                    obr_next   = s_reg;
                    ohp_next   = 1'b0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            unique case (paddr[2])
                dps_pkg::REG_MASTER_BRIGHTNESS:
                begin
                    mb_next = pwdata[7:0];
                end
                dps_pkg::REG_RANDOM_SEED:
                begin
                    seed_next = pwdata[15:0];
                    gen_next  = pwdata[15:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            restart_reg <= 1'b0;
            fading_reg  <= 1'b0;
            eff_reg     <= '0;
            gen_reg     <= dps_pkg::SEED_RESET;
            mb_reg      <= dps_pkg::MB_RESET;
            seed_reg    <= dps_pkg::SEED_RESET;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            restart_reg <= restart_next;
            fading_reg  <= fading_next;
            eff_reg     <= eff_next;
            gen_reg     <= gen_next;
            mb_reg      <= mb_next;
            seed_reg    <= seed_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        d_reg       <= d_next;
        in_life_reg <= in_life_next;
        over_reg    <= over_next;
        life_reg    <= life_next;
        col_reg     <= col_next;
        prod_reg    <= prod_next;
        s_reg       <= s_next;
        oidx_reg    <= oidx_next;
        ored_reg    <= ored_next;
        ogrn_reg    <= ogrn_next;
        oblu_reg    <= oblu_next;
        obr_reg     <= obr_next;
        ohp_reg     <= ohp_next;
        olast_reg   <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dps_pkg::PIXEL_COUNT; i++)
            begin
                start_mem_reg[i] <= '0;
                col_mem_reg[i]   <= '0;
                life_mem_reg[i]  <= dps_pkg::LIFE_RESET;
            end
        end
        else
        begin
            if (we_spawn)
            begin
                start_mem_reg[idx_reg] <= now_reg;
                col_mem_reg[idx_reg]   <= dps_pkg::colour_draw(gen_step);
            end
            if (we_life)
            begin
                life_mem_reg[idx_reg] <= dps_pkg::life_draw(gen_step);
            end
        end
    end

    assign item.ready               = state_reg == S_IDLE;
    assign result.valid             = ov_reg;
    assign result.pixel_index       = oidx_reg;
    assign result.red               = ored_reg;
    assign result.green             = ogrn_reg;
    assign result.blue              = oblu_reg;
    assign result.global_brightness = obr_reg;
    assign result.has_pixel         = ohp_reg;
    assign result.last              = olast_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == dps_pkg::REG_RANDOM_SEED) ? 32'(seed_reg) : 32'(mb_reg);

    `DPS_ASSERT(a_last_pixel_idx,
        ov_reg && ohp_reg && olast_reg |-> oidx_reg == 6'(LAST_IDX),
        "last flag on wrong pixel")
    `DPS_ASSERT(a_bright_only_last, ov_reg && !ohp_reg |-> olast_reg,
        "brightness-only result not last")
    `DPS_ASSERT(a_div_start_free, div_start |-> !div_stat.busy,
        "divider started while busy")
    `DPS_ASSERT(a_emit_needs_slot,
        !$past(ofree) && $past(state_reg) == S_EMIT |-> state_reg == S_EMIT,
        "sequencer left emit without a free result slot")

endmodule
